[rtl/core/lph_pkg.sv]
// ============================================================================
// lph_pkg
// Shared types and constants for the linear-probe hash table core.
// ============================================================================
package lph_pkg;

    localparam int LPH_TABLE_SLOTS = 16;
    localparam int KEY_W           = 31;
    localparam int SLOT_W          = 4;
    localparam int MAX_RESULTS     = 16;
    localparam int LIST_CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int BIT_CNT_W       = $clog2(KEY_W + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_LISTED    = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_LIST,
        S_FLUSH
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key_out;
        logic              last;
    } result_t;

    // write controls from the sequencer to the slot store
    typedef struct packed {
        logic  key_en;
        logic  mark_en;
        mark_t mark;
    } store_wr_t;

endpackage

[rtl/core/lph_home_unit.sv]
// ============================================================================
// lph_home_unit
// Home slot computation: key modulo table size by reciprocal multiplication
// and a multiply-subtract; a plain mask for power-of-two sizes.
// ============================================================================
module lph_home_unit
    import lph_pkg::*;
#(
    parameter int TABLE_SLOTS = LPH_TABLE_SLOTS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam int PROD_W  = 2 * KEY_W + 1;
    // floor(key * RECIP / 2^SHIFT) is the exact quotient for any KEY_W-bit key
    localparam int SHIFT   = KEY_W + IDX_W;
    localparam logic [KEY_W:0] RECIP =
        (KEY_W + 1)'(((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

    logic              run_reg;
    logic [1:0]        step_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  quot_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  diff;

    always_comb
    begin
        prod = PROD_W'(key_reg) * PROD_W'(RECIP);
        diff = key_reg - KEY_W'(quot_reg * KEY_W'(TABLE_SLOTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= IS_POW2 ? 2'd0 : 2'd2;
        end
        else if (run_reg)
        begin
            if (step_reg == '0)
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // step 2: quotient from the reciprocal, step 1: remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
            rem_reg <= key[IDX_W-1:0];
        end
        else if (run_reg && step_reg == 2'd2)
        begin
            quot_reg <= KEY_W'(prod >> SHIFT);
        end
        else if (run_reg && step_reg == 2'd1)
        begin
            rem_reg <= diff[IDX_W-1:0];
        end
    end

    assign done = run_reg && (step_reg == '0);
    assign home = rem_reg;

endmodule

[rtl/core/lph_slot_store.sv]
// ============================================================================
// lph_slot_store
// Slot storage: key memory with registered read, per-slot status marks in
// flops cleared to empty at reset.
// ============================================================================
module lph_slot_store
    import lph_pkg::*;
#(
    parameter int TABLE_SLOTS = LPH_TABLE_SLOTS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    input  logic [$clog2(TABLE_SLOTS)-1:0] idx,
    input  store_wr_t                      wr,
    input  logic [KEY_W-1:0]               wr_key,
    output logic [KEY_W-1:0]               key_q,
    output mark_t                          mark
);

    logic [KEY_W-1:0] key_mem [TABLE_SLOTS];
    mark_t            marks_reg [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            key_mem[idx] <= wr_key;
        end
        key_q <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                marks_reg[i] <= MARK_EMPTY;
            end
        end
        else if (wr.mark_en)
        begin
            marks_reg[idx] <= wr.mark;
        end
    end

    assign mark = marks_reg[idx];

endmodule

[rtl/core/linear_probe_hash_table_core.sv]
// ============================================================================
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing and deleted-slot reuse.
// ============================================================================
// Usage:
//   A transaction is taken on a clock edge with start high and busy low;
//   request carries cmd (insert, delete, list) and key. Unused cmd codes
//   are dropped without a result and busy stays low.
//   Results come out on result for one cycle each, flagged by result_valid;
//   result.last marks the final one of a transaction. There is no
//   backpressure: the receiver must take each result as it appears.
//   Flow: insert/delete spend a home-slot phase (a plain mask for
//   power-of-two TABLE_SLOTS, otherwise a reciprocal multiply, then a
//   multiply-subtract in the modulo unit), then probe one slot per cycle,
//   up to TABLE_SLOTS probes, then register the result. A list scans all
//   slots at one per cycle (stopping after MAX_RESULTS hits) and flushes
//   the final entry. The single key-memory read port and the
//   one-probe-per-cycle sequencer set this pace; one transaction at a
//   time, busy stays high until its last result is out.
//   Reset: all slots empty, sequencer idle, no result pending.
// ============================================================================
module linear_probe_hash_table_core
    import lph_pkg::*;
#(
    parameter int TABLE_SLOTS = LPH_TABLE_SLOTS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output result_t  result,
    output logic     result_valid
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      n_reg, n_next;
    logic [LIST_CNT_W-1:0] list_cnt_reg, list_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_slot_reg, pend_slot_next;
    logic [KEY_W-1:0]      pend_key_reg, pend_key_next;
    result_t               result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    logic                  home_start;
    logic                  home_done;
    logic [IDX_W-1:0]      home;
    store_wr_t             wr;
    logic [KEY_W-1:0]      key_q;
    mark_t                 mark;
    logic                  hit;
    logic                  is_insert;
    logic [LIST_CNT_W-1:0] cnt_inc;

    function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] i);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(i);
        return ext[SLOT_W-1:0];
    endfunction

    lph_home_unit #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (request.key),
        .done  (home_done),
        .home  (home)
    );

    lph_slot_store #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_next),
        .idx     (idx_reg),
        .wr      (wr),
        .wr_key  (key_reg),
        .key_q   (key_q),
        .mark    (mark)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
            list_cnt_reg     <= '0;
            n_reg            <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            pend_valid_reg   <= pend_valid_next;
            list_cnt_reg     <= list_cnt_next;
            n_reg            <= n_next;
            idx_reg          <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        pend_slot_reg <= pend_slot_next;
        pend_key_reg  <= pend_key_next;
        result_reg    <= result_next;
    end

    assign is_insert = (cmd_reg == CMD_INSERT);
    assign hit       = is_insert ? (mark != MARK_USED)
                                 : (mark == MARK_USED && key_q == key_reg);
    assign cnt_inc   = LIST_CNT_W'(list_cnt_reg + 1'b1);

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        idx_next          = idx_reg;
        n_next            = n_reg;
        list_cnt_next     = list_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_key_next     = pend_key_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        home_start        = 1'b0;
        wr                = '{key_en: 1'b0, mark_en: 1'b0, mark: MARK_EMPTY};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = request.cmd;
                    key_next = request.key;
                    case (request.cmd)
                        CMD_INSERT, CMD_DELETE:
                        begin
                            home_start = 1'b1;
                            state_next = S_HOME;
                        end
                        CMD_LIST:
                        begin
                            idx_next        = '0;
                            list_cnt_next   = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_LIST;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HOME:
            begin
                if (home_done)
                begin
                    idx_next   = home;
                    n_next     = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (hit)
                begin
                    wr.mark_en         = 1'b1;
                    wr.key_en          = is_insert;
                    wr.mark            = is_insert ? MARK_USED : MARK_GONE;
                    result_valid_next  = 1'b1;
                    result_next.status = is_insert ? ST_INSERTED : ST_DELETED;
                    result_next.slot   = slot_field(idx_reg);
                    result_next.key_out = key_reg;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
                else if (n_reg == IDX_LAST)
                begin
                    result_valid_next  = 1'b1;
                    result_next.status = is_insert ? ST_FULL : ST_NOT_FOUND;
                    result_next.slot   = '0;
                    result_next.key_out = key_reg;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                    n_next   = n_reg + 1'b1;
                end
            end
            S_LIST:
            begin
                // hold one hit back so the final one can carry last
                if (mark == MARK_USED)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next   = 1'b1;
                        result_next.status  = ST_LISTED;
                        result_next.slot    = slot_field(pend_slot_reg);
                        result_next.key_out = pend_key_reg;
                        result_next.last    = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = idx_reg;
                    pend_key_next   = key_q;
                    list_cnt_next   = cnt_inc;
                end
                if (idx_reg == IDX_LAST ||
                    (mark == MARK_USED && cnt_inc == LIST_CNT_W'(MAX_RESULTS)))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                result_valid_next = 1'b1;
                result_next.last  = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next.status  = ST_LISTED;
                    result_next.slot    = slot_field(pend_slot_reg);
                    result_next.key_out = pend_key_reg;
                end
                else
                begin
                    result_next.status  = ST_EMPTY;
                    result_next.slot    = '0;
                    result_next.key_out = '0;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // every result belongs to a transaction that was in progress
    a_result_in_txn: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a transaction in progress");

    // the sequencer only goes idle when it hands out the final result
    a_idle_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && result.last))
        else $error("transaction ended without a final result");

    // only a list scan produces results that are not the last
    a_nonlast_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (state_reg == S_LIST || state_reg == S_FLUSH))
        else $error("non-final result outside a list scan");

    // modulo unit reports only while the sequencer waits for it
    a_home_done: assert property (@(posedge clk) disable iff (!rst_n)
        home_done |-> (state_reg == S_HOME))
        else $error("home slot ready outside the home phase");

    // list hit count never passes the result cap
    a_list_cap: assert property (@(posedge clk) disable iff (!rst_n)
        list_cnt_reg <= LIST_CNT_W'(MAX_RESULTS))
        else $error("list hit count overflow");

endmodule
